FILE: design/greedy_edge_tour_builder_assert.svh
// Assertion macros for the greedy edge tour builder.
`ifndef GREEDY_EDGE_TOUR_BUILDER_ASSERT_SVH
`define GREEDY_EDGE_TOUR_BUILDER_ASSERT_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define GETB_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication.
`define GETB_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: design/getb_pkg.sv
// Package: constants and types shared by the greedy edge tour builder.
package getb_pkg;
   localparam int MaxVertices = 16;
   localparam int MaxEdges    = 128;
   localparam int VertexBits  = 4;
   localparam int WeightBits  = 16;
   localparam int CountBits   = 5;
   localparam logic [CountBits-1:0] VertexCountReset = 5'd16;
   localparam logic [CountBits-1:0] MinVertices = 5'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR,
      ST_SORT_PUT,
      ST_INIT,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_RELABEL,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT
   } state_type;
endpackage

FILE: design/getb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module getb_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: design/greedy_edge_tour_builder.sv
// Greedy edge tour builder: edge load, insertion sort in RAM, greedy scan.
// Loading accepts one request per cycle while in the load state. After the final
// edge the sort runs (insertion sort on one RAM port), then the greedy scan, in
// which each edge taken by the group test starts a relabel sweep over the graph's
// vertices, then the results are emitted. One graph at a time.
// Synchronous active-high reset returns to loading with vertex_count 16.
module greedy_edge_tour_builder #(
   parameter int MAX_VERTICES = getb_pkg::MaxVertices,
   parameter int MAX_EDGES    = getb_pkg::MaxEdges
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // end_a[3:0], end_b[7:4], edge_weight[23:8]
   input  logic        req_tlast,   // final_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tour_a[3:0], tour_b[7:4], tour_weight[23:8]
   output logic        rsp_tlast,   // tour_last
   output logic        rsp_tuser,   // tour_status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // vertex_count
);
   `include "greedy_edge_tour_builder_assert.svh"
   import getb_pkg::*;

   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int PW  = $clog2(MAX_VERTICES + 1);
   localparam int EW  = 2 * VertexBits + WeightBits;

   state_type state_ff, state_in;
   logic [CountBits-1:0] vcount_ff;
   logic [ECW-1:0] loaded_ff, loaded_in;
   logic [ECW-1:0] i_ff, i_in;
   logic [ECW-1:0] k_ff, k_in;
   logic [EW-1:0]  cur_ff, cur_in;
   logic [PW-1:0]  chosen_ff, chosen_in;
   logic [PW-1:0]  n_ff, n_in;
   logic           done_ff, done_in;
   logic [1:0]     deg_ff [MAX_VERTICES];
   logic [VW-1:0]  grp_ff [MAX_VERTICES];
   logic [VW-1:0]  old_ff, old_in, neu_ff, neu_in;
   logic [PW-1:0]  sweep_ff, sweep_in;
   logic [EW-1:0]  out_data_ff, out_data_in;
   logic           out_last_ff, out_last_in, out_stat_ff, out_stat_in;
   logic           out_valid_ff, out_valid_in;

   // edge store and picked-edge store
   logic          e_we;
   logic [EAW-1:0] e_wa, e_ra;
   logic [EW-1:0] e_wd, e_rd;
   logic          p_we;
   logic [VW-1:0] p_wa, p_ra, p_idx;
   logic [EW-1:0] p_rd;

   getb_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edges (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   getb_ram #(.Width(EW), .Depth(MAX_VERTICES)) u_picked (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(e_rd),
      .rd_addr(p_ra), .rd_data(p_rd));

   // with two vertices the one edge taken is also the closing one: both results read entry 0
   assign p_idx = (n_ff == PW'(2)) ? '0 : k_ff[VW-1:0];

   // fields of the edge read from the store
   logic [VertexBits-1:0] ea, eb;
   logic [WeightBits-1:0] ew, cw;
   assign ea = e_rd[VertexBits-1:0];
   assign eb = e_rd[2*VertexBits-1:VertexBits];
   assign ew = e_rd[EW-1:2*VertexBits];
   assign cw = cur_ff[EW-1:2*VertexBits];

   logic [PW-1:0] va, vb;
   logic [VW-1:0] ia, ib;
   logic ok_edge, take1, take2;
   logic [1:0] da, db;
   assign va = PW'(ea);
   assign vb = PW'(eb);
   assign ia = VW'(ea);
   assign ib = VW'(eb);
   assign ok_edge = (va < n_ff) && (vb < n_ff) && (ea != eb);
   assign take1 = ok_edge && (deg_ff[ia] < 2'd2) && (deg_ff[ib] < 2'd2) &&
                  (grp_ff[ia] != grp_ff[ib]);
   assign da = take1 ? deg_ff[ia] + 2'd1 : deg_ff[ia];
   assign db = take1 ? deg_ff[ib] + 2'd1 : deg_ff[ib];
   assign take2 = ok_edge && ((take1 ? chosen_ff + 1'b1 : chosen_ff) == n_ff - 1'b1) &&
                  (da == 2'd1) && (db == 2'd1);

   logic load_acc;
   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign load_acc   = req_tvalid && req_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         vcount_ff    <= VertexCountReset;
         loaded_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid) begin
            vcount_ff <= csr_data;
         end
      end
   end

   // working registers and vertex tables
   always_ff @(posedge clock) begin
      i_ff <= i_in; k_ff <= k_in; cur_ff <= cur_in; chosen_ff <= chosen_in;
      n_ff <= n_in; done_ff <= done_in; old_ff <= old_in; neu_ff <= neu_in;
      sweep_ff <= sweep_in; out_data_ff <= out_data_in;
      out_last_ff <= out_last_in; out_stat_ff <= out_stat_in;
      if (state_ff == ST_INIT) begin
         for (int v = 0; v < MAX_VERTICES; v++) begin
            deg_ff[v] <= 2'd0;
            grp_ff[v] <= VW'(v);
         end
      end else if (state_ff == ST_SCAN_EVAL) begin
         if (take1 || take2) begin
            deg_ff[ia] <= (take1 && take2) ? da + 2'd1 : (take2 ? da + 2'd1 : da);
            deg_ff[ib] <= (take1 && take2) ? db + 2'd1 : (take2 ? db + 2'd1 : db);
         end
      end else if (state_ff == ST_RELABEL) begin
         if (grp_ff[sweep_ff[VW-1:0]] == old_ff) begin
            grp_ff[sweep_ff[VW-1:0]] <= neu_ff;
         end
      end
   end

   // next state and datapath control
   always_comb begin
      state_in = state_ff; loaded_in = loaded_ff; i_in = i_ff; k_in = k_ff;
      cur_in = cur_ff; chosen_in = chosen_ff; n_in = n_ff; done_in = done_ff;
      old_in = old_ff; neu_in = neu_ff; sweep_in = sweep_ff;
      out_data_in = out_data_ff; out_last_in = out_last_ff;
      out_stat_in = out_stat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      e_we = 1'b0; e_wa = loaded_ff[EAW-1:0]; e_wd = req_tdata[EW-1:0];
      e_ra = i_ff[EAW-1:0];
      p_we = 1'b0; p_wa = chosen_ff[VW-1:0]; p_ra = p_idx;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_acc) begin
               if (loaded_ff < ECW'(MAX_EDGES)) begin
                  e_we = 1'b1;
                  loaded_in = loaded_ff + 1'b1;
               end
               if (req_tlast) begin
                  if (vcount_ff < MinVertices) n_in = PW'(MinVertices);
                  else if (32'(vcount_ff) > MAX_VERTICES) n_in = PW'(MAX_VERTICES);
                  else n_in = PW'(vcount_ff);
                  i_in = ECW'(1);
                  state_in = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            if (i_ff >= loaded_ff) begin
               state_in = ST_INIT;
            end else begin
               e_ra = i_ff[EAW-1:0];
               k_in = i_ff;
               state_in = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            // cur captured; read predecessor
            cur_in = e_rd;
            e_ra = EAW'(k_ff - 1'b1);
            state_in = ST_SORT_WR;
         end
         ST_SORT_WR: begin
            if (k_ff != '0 && cw < ew) begin
               e_we = 1'b1; e_wa = k_ff[EAW-1:0]; e_wd = e_rd;
               k_in = k_ff - 1'b1;
               e_ra = EAW'(k_ff - 2'd2);
               state_in = (k_ff == ECW'(1)) ? ST_SORT_PUT : ST_SORT_WR;
            end else begin
               state_in = ST_SORT_PUT;
            end
         end
         ST_SORT_PUT: begin
            e_we = 1'b1; e_wa = k_ff[EAW-1:0]; e_wd = cur_ff;
            i_in = i_ff + 1'b1;
            state_in = ST_SORT_RD;
         end
         ST_INIT: begin
            chosen_in = '0; done_in = 1'b0; i_in = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (i_ff >= loaded_ff) begin
               k_in = '0; state_in = ST_EMIT_RD;
            end else begin
               e_ra = i_ff[EAW-1:0];
               state_in = ST_SCAN_EVAL;
            end
         end
         ST_SCAN_EVAL: begin
            chosen_in = chosen_ff + PW'(take1) + PW'(take2);
            p_we = take1 || take2;
            i_in = i_ff + 1'b1;
            old_in = grp_ff[ib]; neu_in = grp_ff[ia]; sweep_in = '0;
            if (chosen_in >= n_ff) begin
               done_in = 1'b1; k_in = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = take1 ? ST_RELABEL : ST_SCAN_RD;
            end
         end
         ST_RELABEL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == n_ff - 1'b1) state_in = ST_SCAN_RD;
         end
         ST_EMIT_RD: begin
            p_ra = p_idx;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               if (chosen_ff == '0) begin
                  out_data_in = '0; out_last_in = 1'b1; out_stat_in = 1'b1;
               end else begin
                  out_data_in = p_rd;
                  out_last_in = (k_ff + 1'b1 == ECW'(chosen_ff));
                  out_stat_in = (k_ff + 1'b1 == ECW'(chosen_ff)) && !done_ff;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_last_ff) begin
               loaded_in = '0; state_in = ST_LOAD;
            end else begin
               k_in = k_ff + 1'b1; state_in = ST_EMIT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_stat_ff;

   `GETB_ASSERT_IMP(a_stat_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `GETB_ASSERT_IMP(a_no_load_out, clock, reset, rsp_tvalid, !req_tready || rsp_tlast)
   `GETB_ASSERT_NXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
endmodule

FILE: tb/sv/tb_greedy_edge_tour_builder.sv
// Testbench for the greedy edge tour builder: random graphs, predicted tours.
`timescale 1ns / 1ps
module tb_greedy_edge_tour_builder;
   import getb_pkg::*;

   typedef struct packed {
      logic [3:0]  a;
      logic [3:0]  b;
      logic [15:0] w;
   } edge_rec_type;

   typedef struct packed {
      logic        fin;
      logic [15:0] w;
      logic [3:0]  b;
      logic [3:0]  a;
   } edge_req_type;

   typedef struct packed {
      logic        status;
      logic        last;
      logic [15:0] w;
      logic [3:0]  b;
      logic [3:0]  a;
   } tour_rsp_type;

   localparam int WatchLimit = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;

   greedy_edge_tour_builder u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   edge_rec_type graph_edges[MaxEdges];
   int           graph_len = 0;
   logic [4:0]   vertex_reg = VertexCountReset;
   edge_req_type pending_edges[$];
   tour_rsp_type tour_expect[$];
   int           mismatches = 0;
   int           edges_sent = 0;
   bit           calm = 1'b0;
   bit           req_hs = 1'b0;

   // Store one edge; on the final one, sort, scan and queue the tour.
   task automatic predict_tour(input edge_req_type r);
      edge_rec_type cur;
      edge_rec_type taken[MaxVertices+1];
      int deg[MaxVertices];
      int grp[MaxVertices];
      int n, cnt, k, i, old_g, new_g;
      bit closed;
      tour_rsp_type t;
      if (graph_len < MaxEdges) begin
         graph_edges[graph_len] = '{r.a, r.b, r.w};
         graph_len++;
      end
      if (!r.fin) return;
      n = vertex_reg;
      if (n < 2) n = 2;
      if (n > MaxVertices) n = MaxVertices;
      // stable insertion sort by weight
      for (i = 1; i < graph_len; i++) begin
         cur = graph_edges[i];
         k = i;
         while (k > 0 && cur.w < graph_edges[k-1].w) begin
            graph_edges[k] = graph_edges[k-1];
            k--;
         end
         graph_edges[k] = cur;
      end
      for (i = 0; i < MaxVertices; i++) begin
         deg[i] = 0;
         grp[i] = i;
      end
      cnt = 0;
      closed = 1'b0;
      for (int j = 0; j < graph_len && !closed; j++) begin
         cur = graph_edges[j];
         if (cur.a >= n || cur.b >= n || cur.a == cur.b) continue;
         if (deg[cur.a] < 2 && deg[cur.b] < 2 && grp[cur.a] != grp[cur.b]) begin
            old_g = grp[cur.b];
            new_g = grp[cur.a];
            taken[cnt] = cur;
            cnt++;
            deg[cur.a]++;
            deg[cur.b]++;
            for (i = 0; i < n; i++)
               if (grp[i] == old_g) grp[i] = new_g;
         end
         if (cnt == n - 1 && deg[cur.a] == 1 && deg[cur.b] == 1) begin
            taken[cnt] = cur;
            cnt++;
            deg[cur.a]++;
            deg[cur.b]++;
         end
         if (cnt >= n) closed = 1'b1;
      end
      graph_len = 0;
      if (cnt == 0) begin
         t = '0;
         t.last = 1'b1;
         t.status = 1'b1;
         tour_expect.push_back(t);
      end
      for (k = 0; k < cnt; k++) begin
         t.a = taken[k].a;
         t.b = taken[k].b;
         t.w = taken[k].w;
         t.last = (k + 1 == cnt);
         t.status = t.last && !closed;
         tour_expect.push_back(t);
      end
   endtask

   // request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_hs) begin
            void'(pending_edges.pop_front());
            edges_sent++;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_edges.size() > 0 && (!req_tvalid || req_hs) && !calm
                      && $urandom_range(0, 15) == 0) begin
            req_gap = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
         end else if (pending_edges.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_edges[0].w, pending_edges[0].b, pending_edges[0].a};
            req_tlast  <= pending_edges[0].fin;
         end else begin
            req_tvalid <= 1'b0;
         end
         req_hs = 1'b0;
      end
   end

   // response side stalls
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(1, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   tour_rsp_type got, want;
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            req_hs = 1'b1;
            predict_tour({req_tlast, req_tdata[23:8], req_tdata[7:4], req_tdata[3:0]});
         end
         if (csr_valid && csr_ready) begin
            idle_cycles = 0;
            vertex_reg = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            got = {rsp_tuser, rsp_tlast, rsp_tdata[23:8], rsp_tdata[7:4], rsp_tdata[3:0]};
            if (tour_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %h", got);
            end else begin
               want = tour_expect.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: a %0d/%0d b %0d/%0d w %h/%h last %b/%b status %b/%b",
                              want.a, got.a, want.b, got.b, want.w, got.w,
                              want.last, got.last, want.status, got.status);
               end
            end
         end
         if (idle_cycles >= WatchLimit) begin
            $display("tb_greedy_edge_tour_builder NOT OK");
            $finish;
         end
      end
   end

   // Queue one graph of cnt edges, the last one marked final.
   task automatic queue_graph(input int cnt, input int span, input bit legal,
                              input int wmax);
      edge_req_type r;
      for (int i = 0; i < cnt; i++) begin
         r.a = legal ? 4'($urandom_range(0, span - 1)) : 4'($urandom);
         r.b = legal ? 4'($urandom_range(0, span - 1)) : 4'($urandom);
         r.w = 16'($urandom_range(0, wmax));
         r.fin = (i == cnt - 1);
         pending_edges.push_back(r);
      end
   endtask

   // Queue all edges of a complete graph on span vertices, shuffled.
   task automatic queue_complete(input int span, input int wmax);
      edge_req_type list[$];
      edge_req_type r;
      for (int i = 0; i < span; i++)
         for (int j = i + 1; j < span; j++) begin
            r.a = 4'(i);
            r.b = 4'(j);
            r.w = 16'($urandom_range(0, wmax));
            r.fin = 1'b0;
            list.push_back(r);
         end
      list.shuffle();
      list[list.size()-1].fin = 1'b1;
      foreach (list[i]) pending_edges.push_back(list[i]);
   endtask

   // Wait until the block has drained, then write vertex_count.
   task automatic set_vertices(input logic [4:0] v);
      wait (pending_edges.size() == 0 && !req_tvalid);
      while (tour_expect.size() > 0) @(posedge clock);
      repeat (4000) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   edge_req_type d;
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: two vertices, extremes, bad ends, ties, exhausted graphs
      set_vertices(5'd2);
      d = '{fin: 1'b1, w: 16'hFFFF, b: 4'd1, a: 4'd0};
      pending_edges.push_back(d);
      d = '{fin: 1'b0, w: 16'h0000, b: 4'd15, a: 4'd15};
      pending_edges.push_back(d);
      d = '{fin: 1'b1, w: 16'h0000, b: 4'd0, a: 4'd15};
      pending_edges.push_back(d);
      set_vertices(5'd0);
      d = '{fin: 1'b0, w: 16'h8000, b: 4'd0, a: 4'd1};
      pending_edges.push_back(d);
      d = '{fin: 1'b1, w: 16'h8000, b: 4'd1, a: 4'd0};
      pending_edges.push_back(d);
      set_vertices(5'd4);
      d = '{fin: 1'b0, w: 16'h0001, b: 4'd1, a: 4'd0};
      pending_edges.push_back(d);
      d = '{fin: 1'b0, w: 16'h0001, b: 4'd2, a: 4'd1};
      pending_edges.push_back(d);
      d = '{fin: 1'b1, w: 16'h5555, b: 4'd3, a: 4'd7};
      pending_edges.push_back(d);
      // over-range vertex count and an overfull store
      set_vertices(5'd31);
      queue_graph(MaxEdges + 2, 16, 1'b1, 65535);
      // a few small random graphs
      for (int g = 0; g < 3; g++) begin
         int v;
         v = $urandom_range(2, 5);
         set_vertices(5'(v));
         case ($urandom_range(0, 3))
            0: queue_graph($urandom_range(1, 6), 16, 1'b0, 65535);
            1: queue_graph($urandom_range(2, 8), v, 1'b1, 15);
            default: queue_complete(v, (g % 2) ? 7 : 65535);
         endcase
      end
      // final stretch without idling
      set_vertices(5'd4);
      calm = 1'b1;
      queue_complete(4, 65535);
      queue_complete(4, 3);
      wait (pending_edges.size() == 0 && !req_tvalid);
      while (tour_expect.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && tour_expect.size() == 0)
         $display("tb_greedy_edge_tour_builder OK");
      else
         $display("tb_greedy_edge_tour_builder NOT OK");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+design
design/getb_pkg.sv
design/getb_ram.sv
design/greedy_edge_tour_builder.sv
tb/sv/tb_greedy_edge_tour_builder.sv
